// ===== hw/rtl/cdsc_pkg.sv =====
// shared constants, stage types and calendar tables for the day streak counter
package cdsc_pkg;

  localparam int DATE_W   = 64;
  localparam int USE_W    = 16;
  localparam int STREAK_W = 16;
  localparam int DAY_W    = 23;

  // days in one 400-year era, and days from 0000-03-01 to 1970-01-01
  localparam int ERA_DAYS  = 146097;
  localparam int EPOCH_OFS = 719468;

  // after the digit check: century and year split, shifted to a march-based year
  typedef struct packed {
    logic              list_start;
    logic              ok_use;
    logic              date_ok;
    logic signed [7:0] cent_adj;
    logic [6:0]        year_adj;
    logic [3:0]        month_idx;
    logic [4:0]        day;
  } s1_t;

  // after the day-number arithmetic
  typedef struct packed {
    logic                    list_start;
    logic                    ok_use;
    logic                    date_ok;
    logic signed [DAY_W-1:0] day_num;
  } s2_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // days from 1 march to the first of the month, month index 0 is march
  function automatic logic [8:0] march_offset(input logic [3:0] idx);
    logic [8:0] ofs;
    unique case (idx)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== hw/rtl/current_day_streak_counter.sv =====
// day streak counter: date check, day-number conversion and run count
// three pipeline stages (parse, day number, streak update); a request passes the
// stage 1, stage 2 and output registers; one request per cycle while out_stall is low
// the streak update is the only loop and closes within the last stage
// synchronous active-low reset empties the pipeline, clears the streak state and
// sets the usage threshold to 4.0 h
module current_day_streak_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [cdsc_pkg::USE_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_list_start,
  input  logic [cdsc_pkg::DATE_W-1:0]          in_date_text,
  input  logic [cdsc_pkg::USE_W-1:0]           in_usage_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cdsc_pkg::STREAK_W-1:0]        out_streak_length,
  output logic                                 out_streak_ended,
  output logic                                 out_date_valid,
  output logic signed [cdsc_pkg::DAY_W-1:0]    out_day_number
);
  import cdsc_pkg::*;

  logic [USE_W-1:0]        threshold_r;
  logic                    s1_v_r, s2_v_r, out_v_r;
  s1_t                     s1_r, s1_nxt;
  s2_t                     s2_r, s2_nxt;
  logic [STREAK_W-1:0]     count_r, count_nxt;
  logic signed [DAY_W-1:0] prev_day_r, prev_day_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [STREAK_W-1:0]     len_r;
  logic                    ended_r, dvalid_r;
  logic signed [DAY_W-1:0] dnum_r;

  logic out_free, s2_move, s2_free, s1_move, s1_free, in_acc;

  // flow control
  assign out_free = !out_v_r || !out_stall;
  assign s2_move  = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || s2_move;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_move;
  assign in_acc   = in_valid && s1_free;
  assign in_stall = !s1_free;

  // stage 1: digit check, calendar range check, usage check and march-based year split
  logic [3:0] dig [8];
  logic [7:0] dig_ok;
  logic [6:0] cent, yy, mon, dom;
  logic       leap;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dig_ok[i] = (in_date_text[DATE_W-1-8*i -: 8] >= 8'h30) &&
                  (in_date_text[DATE_W-1-8*i -: 8] <= 8'h39);
      dig[i]    = in_date_text[DATE_W-5-8*i -: 4];
    end
    cent = 7'(dig[0]) * 7'd10 + 7'(dig[1]);
    yy   = 7'(dig[2]) * 7'd10 + 7'(dig[3]);
    mon  = 7'(dig[4]) * 7'd10 + 7'(dig[5]);
    dom  = 7'(dig[6]) * 7'd10 + 7'(dig[7]);
    // leap: year divisible by 4, centuries only when divisible by 400
    leap = (yy == 7'd0) ? (cent[1:0] == 2'd0) : (yy[1:0] == 2'd0);

    s1_nxt.list_start = in_list_start;
    s1_nxt.ok_use     = in_usage_time >= threshold_r;
    s1_nxt.date_ok    = (&dig_ok) && (mon >= 7'd1) && (mon <= 7'd12) &&
                        (dom >= 7'd1) && (dom <= 7'd31) &&
                        (dom[4:0] <= month_len(mon[3:0], leap));
    s1_nxt.day        = dom[4:0];
    // january and february count towards the previous year
    if (mon <= 7'd2) begin
      s1_nxt.month_idx = 4'(mon + 7'd9);
      if (yy == 7'd0) begin
        s1_nxt.cent_adj = $signed({1'b0, cent}) - 8'sd1;
        s1_nxt.year_adj = 7'd99;
      end else begin
        s1_nxt.cent_adj = $signed({1'b0, cent});
        s1_nxt.year_adj = yy - 7'd1;
      end
    end else begin
      s1_nxt.month_idx = 4'(mon - 7'd3);
      s1_nxt.cent_adj  = $signed({1'b0, cent});
      s1_nxt.year_adj  = yy;
    end
  end

  // stage 2: day number, era from century div 4, year of era from the rest
  logic signed [5:0]  era;
  logic [1:0]         cent_mod;
  logic [8:0]         yoe;
  logic [6:0]         leap_days;
  logic [17:0]        doe;
  logic signed [24:0] era_ext, era_days, days;

  always_comb begin
    era       = 6'(s1_r.cent_adj >>> 2);
    cent_mod  = s1_r.cent_adj[1:0];
    yoe       = 9'(cent_mod) * 9'd100 + 9'(s1_r.year_adj);
    // yoe/4 - yoe/100 with yoe/100 equal to the century remainder
    leap_days = 7'(cent_mod) * 7'd25 + 7'(s1_r.year_adj[6:2]);
    doe       = 18'(yoe) * 18'd365 + 18'(leap_days) - 18'(cent_mod) +
                18'(march_offset(s1_r.month_idx)) + 18'(s1_r.day) - 18'd1;
    era_ext   = {{19{era[5]}}, era};
    era_days  = era_ext * 25'(ERA_DAYS);
    days      = era_days + $signed({7'b0, doe}) - 25'(EPOCH_OFS);

    s2_nxt.list_start = s1_r.list_start;
    s2_nxt.ok_use     = s1_r.ok_use;
    s2_nxt.date_ok    = s1_r.date_ok;
    s2_nxt.day_num    = s1_r.date_ok ? days[DAY_W-1:0] : '0;
  end

  // stage 3: streak update
  logic [STREAK_W-1:0]     cnt_cur;
  logic signed [DAY_W-1:0] prev_cur;
  logic                    stp_cur;
  logic signed [DAY_W:0]   gap;

  always_comb begin
    cnt_cur  = s2_r.list_start ? '0 : count_r;
    prev_cur = s2_r.list_start ? '0 : prev_day_r;
    stp_cur  = s2_r.list_start ? 1'b0 : stopped_r;
    gap      = {prev_cur[DAY_W-1], prev_cur} - {s2_r.day_num[DAY_W-1], s2_r.day_num};

    count_nxt    = cnt_cur;
    prev_day_nxt = prev_cur;
    stopped_nxt  = stp_cur;
    if (!stp_cur) begin
      if (!s2_r.date_ok) begin
        stopped_nxt = 1'b1;
      end else if (cnt_cur == '0) begin
        if (s2_r.ok_use) begin
          count_nxt    = STREAK_W'(1);
          prev_day_nxt = s2_r.day_num;
        end else begin
          stopped_nxt = 1'b1;
        end
      end else if (gap == (DAY_W+1)'(1) && s2_r.ok_use) begin
        if (cnt_cur != '1) begin
          count_nxt = cnt_cur + STREAK_W'(1);
        end
        prev_day_nxt = s2_r.day_num;
      end else begin
        stopped_nxt = 1'b1;
      end
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= USE_W'(1024);
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      count_r     <= '0;
      prev_day_r  <= '0;
      stopped_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      if (s1_free) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (s2_move) begin
        count_r    <= count_nxt;
        prev_day_r <= prev_day_nxt;
        stopped_r  <= stopped_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      s2_r <= s2_nxt;
    end
    if (s2_move) begin
      len_r    <= count_nxt;
      ended_r  <= stopped_nxt;
      dvalid_r <= s2_r.date_ok;
      dnum_r   <= s2_r.day_num;
    end
  end

  assign out_valid         = out_v_r;
  assign out_streak_length = len_r;
  assign out_streak_ended  = ended_r;
  assign out_date_valid    = dvalid_r;
  assign out_day_number    = dnum_r;

endmodule

// ===== sim/tb_current_day_streak_counter.sv =====
// testbench for the day streak counter: directed and random night records against a predictor
module tb_current_day_streak_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import cdsc_pkg::*;

  localparam logic [7:0]       ASCII_ZERO  = 8'h30;
  localparam logic [7:0]       ASCII_NINE  = 8'h39;
  localparam logic [USE_W-1:0] THR_RESET   = 16'h0400;
  localparam logic [USE_W-1:0] USE_MAX     = 16'hFFFF;
  localparam logic [STREAK_W-1:0] RUN_MAX  = 16'hFFFF;
  localparam int               CYCLE_LIMIT = 1000000;
  localparam int               SETTLE      = 8;
  localparam int               MAX_REPORTS = 10;

  typedef struct packed {
    logic [STREAK_W-1:0] streak;
    logic                ended;
    logic                date_ok;
    logic [DAY_W-1:0]    day;
  } night_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [USE_W-1:0]           cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_list_start = 1'b0;
  logic [DATE_W-1:0]          in_date_text = '0;
  logic [USE_W-1:0]           in_usage_time = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STREAK_W-1:0]        out_streak_length;
  logic                       out_streak_ended;
  logic                       out_date_valid;
  logic signed [DAY_W-1:0]    out_day_number;

  // predictor state
  logic [USE_W-1:0]    threshold = THR_RESET;
  logic [STREAK_W-1:0] run_length = '0;
  int                  last_day = 0;
  logic                run_broken = 1'b0;

  night_result_t expected_nights[$];
  int          bad_results = 0;
  int          nights_sent = 0;
  int          cycle_count = 0;
  int          hold_request = 0;
  int          stall_left = 0;
  bit          idling = 1'b1;

  current_day_streak_counter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_list_start    (in_list_start),
    .in_date_text     (in_date_text),
    .in_usage_time    (in_usage_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_streak_length(out_streak_length),
    .out_streak_ended (out_streak_ended),
    .out_date_valid   (out_date_valid),
    .out_day_number   (out_day_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int month_days(int y, int m);
    int n;
    case (m)
      2:             n = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // calendar date to days since 1970-01-01, march-based years in 400-year eras
  function automatic logic date_to_day(input logic [DATE_W-1:0] txt, output int days);
    int dig[8];
    int y, m, d, ya, era, yoe, doy, doe, i;
    logic [7:0] c;
    days = 0;
    for (i = 0; i < 8; i++) begin
      c = txt[DATE_W-1-8*i -: 8];
      if (c < ASCII_ZERO || c > ASCII_NINE) return 1'b0;
      dig[i] = c - ASCII_ZERO;
    end
    y = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
    m = dig[4] * 10 + dig[5];
    d = dig[6] * 10 + dig[7];
    if (m < 1 || m > 12 || d < 1 || d > 31) return 1'b0;
    if (d > month_days(y, m)) return 1'b0;
    ya  = (m <= 2) ? y - 1 : y;
    era = (ya >= 0 ? ya : ya - 399) / 400;
    yoe = ya - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * ERA_DAYS + doe - EPOCH_OFS;
    return 1'b1;
  endfunction

  function automatic night_result_t predict_night(logic ls, logic [DATE_W-1:0] txt,
                                                  logic [USE_W-1:0] usage);
    night_result_t r;
    int days;
    logic ok_date, enough;
    if (ls) begin
      run_length = '0;
      last_day   = 0;
      run_broken = 1'b0;
    end
    ok_date = date_to_day(txt, days);
    enough  = usage >= threshold;
    if (!run_broken) begin
      if (!ok_date) begin
        run_broken = 1'b1;
      end else if (run_length == 0) begin
        if (enough) begin
          run_length = STREAK_W'(1);
          last_day   = days;
        end else begin
          run_broken = 1'b1;
        end
      end else if (last_day - days == 1 && enough) begin
        if (run_length != RUN_MAX) run_length++;
        last_day = days;
      end else begin
        run_broken = 1'b1;
      end
    end
    r.streak  = run_length;
    r.ended   = run_broken;
    r.date_ok = ok_date;
    r.day     = days[DAY_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] digit_char(int v);
    return ASCII_ZERO + 8'(v % 10);
  endfunction

  function automatic logic [DATE_W-1:0] ymd_text(int y, int m, int d);
    return {digit_char(y / 1000), digit_char(y / 100), digit_char(y / 10), digit_char(y),
            digit_char(m / 10), digit_char(m), digit_char(d / 10), digit_char(d)};
  endfunction

  function automatic void step_back(inout int y, inout int m, inout int d);
    if (d > 1) begin
      d--;
    end else begin
      if (m > 1) begin
        m--;
      end else begin
        m = 12;
        y--;
      end
      d = month_days(y, m);
    end
  endfunction

  function automatic logic [USE_W-1:0] long_enough();
    if ($urandom_range(0, 7) == 0) return threshold;
    return USE_W'($urandom_range(USE_MAX, threshold));
  endfunction

  function automatic logic [USE_W-1:0] too_short();
    if (threshold == 0) return '0;
    return USE_W'($urandom_range(threshold - 1, 0));
  endfunction

  // receiver: random stall bursts, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request > 0) begin
      out_stall <= 1'b1;
      stall_left = hold_request - 1;
      hold_request = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    night_result_t got, want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_streak_length, out_streak_ended, out_date_valid, out_day_number};
      if (expected_nights.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: streak %0d ended %b valid %b day %0d",
                   got.streak, got.ended, got.date_ok, $signed(got.day));
      end else begin
        want = expected_nights.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: streak %0d/%0d ended %b/%b valid %b/%b day %0d/%0d (exp/act)",
                     want.streak, got.streak, want.ended, got.ended, want.date_ok,
                     got.date_ok, $signed(want.day), $signed(got.day));
        end
      end
    end
  end

  task automatic send_night(input logic ls, input logic [DATE_W-1:0] txt,
                            input logic [USE_W-1:0] usage);
    int gap;
    night_result_t pred;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_list_start <= ls;
    in_date_text  <= txt;
    in_usage_time <= usage;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = predict_night(ls, txt, usage);
    expected_nights.insert(expected_nights.size(), pred);
    nights_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_nights.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [USE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = v;
  endtask

  // a run of consecutive nights with the odd gap, repeat, short night or damaged date
  task automatic send_random_list(input logic with_start);
    int y, m, d, n, k, brk, back;
    logic [DATE_W-1:0] txt;
    logic [USE_W-1:0] usage;
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_days(y, m));
    n = $urandom_range(1, 20);
    for (k = 0; k < n; k++) begin
      txt   = ymd_text(y, m, d);
      usage = long_enough();
      brk   = $urandom_range(0, 24);
      back  = 1;
      case (brk)
        0: usage = too_short();
        1: txt = txt ^ (64'd1 << $urandom_range(0, 63));
        2: back = 2;
        3: back = 0;
        default: ;
      endcase
      send_night(with_start && k == 0, txt, usage);
      repeat (back) step_back(y, m, d);
    end
  endtask

  task automatic test_directed_nights();
    // first request after reset carries no list start
    send_night(1'b0, "20240301", THR_RESET);
    send_night(1'b0, "20240229", USE_MAX);
    send_night(1'b0, "20240228", THR_RESET);
    send_night(1'b0, "20240227", THR_RESET - USE_W'(1));
    send_night(1'b0, "20240226", USE_MAX);
    send_night(1'b1, "99991231", USE_MAX);
    send_night(1'b0, "99991230", THR_RESET);
    send_night(1'b0, "99991230", USE_MAX);
    send_night(1'b1, "00000301", THR_RESET);
    send_night(1'b0, "00000229", THR_RESET);
    send_night(1'b1, "00000101", THR_RESET);
    send_night(1'b0, "00000102", THR_RESET);
    send_night(1'b1, "19000229", USE_MAX);
    send_night(1'b1, "20000229", 16'h0000);
    send_night(1'b1, "19700101", THR_RESET);
    send_night(1'b0, "19691231", USE_MAX);
    // bad date in the middle of a run keeps the count
    send_night(1'b0, "1969123:", USE_MAX);
    send_night(1'b1, "20230431", USE_MAX);
    send_night(1'b1, "20231301", USE_MAX);
    send_night(1'b1, "20230001", USE_MAX);
    send_night(1'b1, "20230100", USE_MAX);
    send_night(1'b1, "20230132", USE_MAX);
    send_night(1'b1, "2023/101", USE_MAX);
    send_night(1'b1, 64'h0, 16'h0000);
    send_night(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, USE_MAX);
    wait_results_drained();
  endtask

  task automatic test_threshold_settings();
    logic [USE_W-1:0] levels[5];
    logic [USE_W-1:0] usage;
    int i, j, k, y, m, d;
    levels = '{16'h0000, USE_MAX, 16'h0001, 16'hFFFE, USE_W'($urandom)};
    for (i = 0; i < 5; i++) begin
      write_threshold(levels[i]);
      for (j = 0; j < 3; j++) begin
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(y, m));
        for (k = 0; k < 6; k++) begin
          case ($urandom_range(0, 4))
            0: usage = threshold;
            1: usage = threshold - USE_W'(1);
            2: usage = '0;
            3: usage = USE_MAX;
            default: usage = USE_W'($urandom);
          endcase
          send_night(k == 0, ymd_text(y, m, d), usage);
          step_back(y, m, d);
        end
      end
      wait_results_drained();
    end
  endtask

  task automatic test_random_lists();
    int first, retune;
    first  = nights_sent;
    retune = nights_sent;
    while (nights_sent - first < 340) begin
      if (nights_sent >= retune) begin
        wait_results_drained();
        write_threshold($urandom_range(0, 3) == 0 ? USE_W'($urandom)
                                                  : USE_W'($urandom_range(0, 16'h0C00)));
        retune = nights_sent + 100;
      end
      case ($urandom_range(0, 9))
        7: send_night(1'($urandom), {$urandom, $urandom}, USE_W'($urandom));
        8: send_night(1'($urandom),
                      ymd_text($urandom_range(0, 9999), $urandom_range(0, 99),
                               $urandom_range(0, 99)),
                      USE_W'($urandom));
        9: send_random_list(1'b0);
        default: send_random_list(1'b1);
      endcase
    end
    wait_results_drained();
    write_threshold(THR_RESET);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_hold();
    int k, y, m, d;
    idling = 1'b0;
    hold_request = 300;
    @(posedge clk);
    y = 2020;
    m = 6;
    d = 15;
    for (k = 0; k < 40; k++) begin
      send_night(k == 0, ymd_text(y, m, d), long_enough());
      step_back(y, m, d);
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_nights();
    test_threshold_settings();
    test_random_lists();
    test_output_hold();
    if (bad_results == 0 && expected_nights.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
